>>> rtl/i2cbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and constants of the I2C bit-level master unit.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

	localparam int unsigned HALF_W = 16;
	localparam logic [HALF_W-1:0] HALF_RESET = 16'd100;

	// command kinds
	localparam logic [2:0] KIND_START = 3'd0;
	localparam logic [2:0] KIND_STOP  = 3'd1;
	localparam logic [2:0] KIND_WRITE = 3'd2;
	localparam logic [2:0] KIND_READ  = 3'd3;
	localparam logic [2:0] KIND_ACK   = 3'd4;
	localparam logic [2:0] KIND_NOACK = 3'd5;

	// register map
	localparam int unsigned ADDR_W = 3;
	localparam logic [ADDR_W-1:0] ADDR_HALF_PERIOD = 3'd0;
	localparam logic [ADDR_W-1:0] ADDR_SEL_MASK = 3'b100;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] kind;
		logic [7:0] tx_byte;
		logic       sda_in;
	} cmd_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       sda_enable;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_bit;
	} res_t;

endpackage

>>> rtl/i2cbm_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_cmd_if
// Tick channel into the master: optional command plus sampled SDA level.
// ----------------------------------------------------------------------------
interface i2cbm_cmd_if;
	logic       valid;
	logic       ready;
	logic       cmd_valid;
	logic [2:0] kind;
	logic [7:0] tx_byte;
	logic       sda_in;

	modport source (output valid, cmd_valid, kind, tx_byte, sda_in, input ready);
	modport sink (input valid, cmd_valid, kind, tx_byte, sda_in, output ready);
endinterface

>>> rtl/i2cbm_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_res_if
// Per-tick status channel out of the master: line levels and results.
// ----------------------------------------------------------------------------
interface i2cbm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       sda_enable;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_bit;

	modport source (output valid, scl_out, sda_out, sda_enable, busy_res, done_res,
		rx_byte, ack_bit, input ready);
	modport sink (input valid, scl_out, sda_out, sda_enable, busy_res, done_res,
		rx_byte, ack_bit, output ready);
endinterface

>>> rtl/i2cbm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_cfg
// APB register slave holding the half-period length.
// ----------------------------------------------------------------------------
module i2cbm_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [i2cbm_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output logic [i2cbm_pkg::HALF_W-1:0]   half_period
);

	logic [i2cbm_pkg::HALF_W-1:0] half_q;
	logic                         hit;

	assign hit = (paddr & i2cbm_pkg::ADDR_SEL_MASK) == i2cbm_pkg::ADDR_HALF_PERIOD;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= i2cbm_pkg::HALF_RESET;
		end else if (psel && penable && pwrite && hit) begin
			half_q <= pwdata[i2cbm_pkg::HALF_W-1:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (hit) begin
			prdata[i2cbm_pkg::HALF_W-1:0] = half_q;
		end
	end

	assign half_period = half_q;

endmodule

>>> rtl/i2cbm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_seq
// Line sequencer state machine: advances one tick per accepted request and
// presents the status after that tick.
// ----------------------------------------------------------------------------
module i2cbm_seq #(
	parameter int unsigned WAIT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  i2cbm_pkg::cmd_t              cmd,
	input  logic [i2cbm_pkg::HALF_W-1:0] half_period,
	output i2cbm_pkg::res_t              res
);

	typedef enum logic [16:0] {
		PH_IDLE     = 17'h00001,
		PH_START1   = 17'h00002,
		PH_START2   = 17'h00004,
		PH_STOP1    = 17'h00008,
		PH_STOP2    = 17'h00010,
		PH_WR_HI    = 17'h00020,
		PH_WR_LO    = 17'h00040,
		PH_WR_ACKHI = 17'h00080,
		PH_WR_ACKSM = 17'h00100,
		PH_RD_HI    = 17'h00200,
		PH_RD_LO    = 17'h00400,
		PH_AK_GAP   = 17'h00800,
		PH_AK_HI    = 17'h01000,
		PH_AK_LO    = 17'h02000,
		PH_NA_GAP   = 17'h04000,
		PH_NA_HI    = 17'h08000,
		PH_NA_END   = 17'h10000
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [3:0]            bit_cnt_q, bit_cnt_d;
	logic [7:0]            shift_q, shift_d;
	logic [WAIT_WIDTH-1:0] wait_q, wait_d;
	logic                  scl_q, scl_d;
	logic                  sda_q, sda_d;
	logic                  drive_q, drive_d;
	logic                  ack_q, ack_d;
	logic [7:0]            rx_q, rx_d;
	logic                  done;
	logic                  fire;

	logic [31:0]           half_ext;
	logic [WAIT_WIDTH-1:0] wait_raw;
	logic [WAIT_WIDTH-1:0] wait_len;

	// wait length in the counter width, zero acts as one
	assign half_ext = {{(32-i2cbm_pkg::HALF_W){1'b0}}, half_period};
	assign wait_raw = half_ext[WAIT_WIDTH-1:0];
	assign wait_len = (wait_raw == '0) ? {{(WAIT_WIDTH-1){1'b0}}, 1'b1} : wait_raw;

	assign fire = wait_q <= {{(WAIT_WIDTH-1){1'b0}}, 1'b1};

	always_comb begin
		phase_d   = phase_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		wait_d    = wait_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		drive_d   = drive_q;
		ack_d     = ack_q;
		rx_d      = rx_q;
		done      = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (cmd.cmd_valid) begin
				case (cmd.kind)
					i2cbm_pkg::KIND_START: begin
						drive_d = 1'b1;
						sda_d   = 1'b1;
						scl_d   = 1'b1;
						phase_d = PH_START1;
						wait_d  = wait_len;
					end
					i2cbm_pkg::KIND_STOP: begin
						drive_d = 1'b1;
						sda_d   = 1'b0;
						phase_d = PH_STOP1;
						wait_d  = wait_len;
					end
					i2cbm_pkg::KIND_WRITE: begin
						drive_d   = 1'b1;
						shift_d   = cmd.tx_byte;
						bit_cnt_d = 4'd0;
						sda_d     = cmd.tx_byte[7];
						phase_d   = PH_WR_HI;
						wait_d    = wait_len;
					end
					i2cbm_pkg::KIND_READ: begin
						drive_d   = 1'b0;
						shift_d   = 8'd0;
						bit_cnt_d = 4'd0;
						phase_d   = PH_RD_HI;
						wait_d    = wait_len;
					end
					i2cbm_pkg::KIND_ACK: begin
						drive_d = 1'b1;
						sda_d   = 1'b0;
						phase_d = PH_AK_GAP;
						wait_d  = wait_len;
					end
					i2cbm_pkg::KIND_NOACK: begin
						drive_d = 1'b1;
						sda_d   = 1'b1;
						phase_d = PH_NA_GAP;
						wait_d  = wait_len;
					end
					default: begin
					end
				endcase
			end
		end else if (!fire) begin
			wait_d = wait_q - {{(WAIT_WIDTH-1){1'b0}}, 1'b1};
		end else begin
			case (phase_q)
				PH_START1: begin
					sda_d   = 1'b0;
					phase_d = PH_START2;
					wait_d  = wait_len;
				end
				PH_START2: begin
					scl_d = 1'b0;
					done  = 1'b1;
				end
				PH_STOP1: begin
					scl_d   = 1'b1;
					phase_d = PH_STOP2;
					wait_d  = wait_len;
				end
				PH_STOP2: begin
					sda_d = 1'b1;
					done  = 1'b1;
				end
				PH_WR_HI: begin
					scl_d   = 1'b1;
					phase_d = PH_WR_LO;
					wait_d  = wait_len;
				end
				PH_WR_LO: begin
					scl_d     = 1'b0;
					shift_d   = {shift_q[6:0], 1'b0};
					bit_cnt_d = bit_cnt_q + 4'd1;
					wait_d    = wait_len;
					if (bit_cnt_d < 4'd8) begin
						sda_d   = shift_d[7];
						phase_d = PH_WR_HI;
					end else begin
						drive_d = 1'b0;
						sda_d   = 1'b1;
						phase_d = PH_WR_ACKHI;
					end
				end
				PH_WR_ACKHI: begin
					scl_d   = 1'b1;
					phase_d = PH_WR_ACKSM;
					wait_d  = wait_len;
				end
				PH_WR_ACKSM: begin
					ack_d = cmd.sda_in;
					scl_d = 1'b0;
					done  = 1'b1;
				end
				PH_RD_HI: begin
					scl_d   = 1'b1;
					phase_d = PH_RD_LO;
					wait_d  = wait_len;
				end
				PH_RD_LO: begin
					shift_d   = {shift_q[6:0], cmd.sda_in};
					scl_d     = 1'b0;
					bit_cnt_d = bit_cnt_q + 4'd1;
					if (bit_cnt_d < 4'd8) begin
						phase_d = PH_RD_HI;
						wait_d  = wait_len;
					end else begin
						rx_d = shift_d;
						done = 1'b1;
					end
				end
				PH_AK_GAP: begin
					phase_d = PH_AK_HI;
					wait_d  = wait_len;
				end
				PH_AK_HI: begin
					scl_d   = 1'b1;
					phase_d = PH_AK_LO;
					wait_d  = wait_len;
				end
				PH_AK_LO: begin
					scl_d = 1'b0;
					sda_d = 1'b1;
					done  = 1'b1;
				end
				PH_NA_GAP: begin
					phase_d = PH_NA_HI;
					wait_d  = wait_len;
				end
				PH_NA_HI: begin
					scl_d   = 1'b1;
					phase_d = PH_NA_END;
					wait_d  = wait_len;
				end
				PH_NA_END: begin
					scl_d = 1'b1;
					done  = 1'b1;
				end
				default: begin
					done = 1'b1;
				end
			endcase
			if (done) begin
				phase_d = PH_IDLE;
				wait_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_cnt_q <= 4'd0;
			shift_q   <= 8'd0;
			wait_q    <= '0;
			scl_q     <= 1'b1;
			sda_q     <= 1'b1;
			drive_q   <= 1'b0;
			ack_q     <= 1'b0;
			rx_q      <= 8'd0;
		end else if (adv) begin
			phase_q   <= phase_d;
			bit_cnt_q <= bit_cnt_d;
			shift_q   <= shift_d;
			wait_q    <= wait_d;
			scl_q     <= scl_d;
			sda_q     <= sda_d;
			drive_q   <= drive_d;
			ack_q     <= ack_d;
			rx_q      <= rx_d;
		end
	end

	// status after this tick
	always_comb begin
		res.scl_out    = scl_d;
		res.sda_out    = sda_d;
		res.sda_enable = drive_d;
		res.busy_res   = phase_d != PH_IDLE;
		res.done_res   = done;
		res.rx_byte    = rx_d;
		res.ack_bit    = ack_d;
	end

endmodule

>>> rtl/i2c_bit_level_master_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bit_level_master_unit
// I2C bit-level master: start, stop, byte write with ack sample, byte read,
// ack and no-ack sequences, paced by a programmable half-period.
// ----------------------------------------------------------------------------
// Every request on cmd is one time tick and yields exactly one status item on
// res in the next cycle. One tick is taken each clock cycle; the only limit is
// the single output register, so cmd.ready drops only while res is stalled.
// Commands are honored only on ticks where the sequencer is idle. Each line
// wait lasts half_period_ticks ticks (register at byte address 0, reset 100,
// zero acts as one), counted in a WAIT_WIDTH-bit down counter.
module i2c_bit_level_master_unit #(
	parameter int unsigned WAIT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	i2cbm_cmd_if.sink                    cmd,
	i2cbm_res_if.source                  res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [i2cbm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	logic [i2cbm_pkg::HALF_W-1:0] half_period;
	i2cbm_pkg::cmd_t              cmd_w;
	i2cbm_pkg::res_t              res_w;
	i2cbm_pkg::res_t              res_q;
	logic                         out_valid_q;
	logic                         adv;

	i2cbm_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.half_period (half_period)
	);

	assign cmd.ready = !out_valid_q || res.ready;
	assign adv = cmd.valid && cmd.ready;

	always_comb begin
		cmd_w.cmd_valid = cmd.cmd_valid;
		cmd_w.kind      = cmd.kind;
		cmd_w.tx_byte   = cmd.tx_byte;
		cmd_w.sda_in    = cmd.sda_in;
	end

	i2cbm_seq #(
		.WAIT_WIDTH (WAIT_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.cmd         (cmd_w),
		.half_period (half_period),
		.res         (res_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_w;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.scl_out    = res_q.scl_out;
	assign res.sda_out    = res_q.sda_out;
	assign res.sda_enable = res_q.sda_enable;
	assign res.busy_res   = res_q.busy_res;
	assign res.done_res   = res_q.done_res;
	assign res.rx_byte    = res_q.rx_byte;
	assign res.ack_bit    = res_q.ack_bit;

endmodule
